// ===== rtl/core/i2r_pkg.sv =====
// ----------------------------------------------------------------------------
// i2r_pkg: shared types and constants for the integer to Roman encoder
// Holds the microcode word layout, the microcode table, the ASCII codes of
// the numeral letters and the control/status structs of the datapath.
// ----------------------------------------------------------------------------
package i2r_pkg;

  localparam int unsigned ValueW  = 12;
  localparam int unsigned CharW   = 7;
  localparam int unsigned AmountW = 10;
  localparam int unsigned UaddrW  = 4;

  localparam logic [ValueW-1:0] ValueMax = 12'd3999;

  // ASCII codes of the numeral letters
  localparam logic [CharW-1:0] CH_NONE = 7'h00;
  localparam logic [CharW-1:0] CH_I    = 7'h49;
  localparam logic [CharW-1:0] CH_V    = 7'h56;
  localparam logic [CharW-1:0] CH_X    = 7'h58;
  localparam logic [CharW-1:0] CH_L    = 7'h4C;
  localparam logic [CharW-1:0] CH_C    = 7'h43;
  localparam logic [CharW-1:0] CH_D    = 7'h44;
  localparam logic [CharW-1:0] CH_M    = 7'h4D;

  // Microcode addresses, one step per numeral value
  localparam logic [UaddrW-1:0] UA_1000 = 4'd0;
  localparam logic [UaddrW-1:0] UA_900  = 4'd1;
  localparam logic [UaddrW-1:0] UA_500  = 4'd2;
  localparam logic [UaddrW-1:0] UA_400  = 4'd3;
  localparam logic [UaddrW-1:0] UA_100  = 4'd4;
  localparam logic [UaddrW-1:0] UA_90   = 4'd5;
  localparam logic [UaddrW-1:0] UA_50   = 4'd6;
  localparam logic [UaddrW-1:0] UA_40   = 4'd7;
  localparam logic [UaddrW-1:0] UA_10   = 4'd8;
  localparam logic [UaddrW-1:0] UA_9    = 4'd9;
  localparam logic [UaddrW-1:0] UA_5    = 4'd10;
  localparam logic [UaddrW-1:0] UA_4    = 4'd11;
  localparam logic [UaddrW-1:0] UA_1    = 4'd12;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  // One control word: amount to test and subtract, letters to send,
  // jump target when the amount fits and when it does not
  typedef struct packed {
    logic [AmountW-1:0] amount;
    logic [CharW-1:0]   first;
    logic [CharW-1:0]   second;
    logic [UaddrW-1:0]  take_addr;
    logic [UaddrW-1:0]  skip_addr;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    logic               load;
    logic               sub;
    logic [AmountW-1:0] amount;
  } dp_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic ge;         // remaining >= amount
    logic diff_zero;  // remaining - amount == 0
    logic rem_zero;   // remaining == 0
  } dp_stat_t;

  // Microcode table. After a taken step the jump skips steps that can no
  // longer fit (e.g. after 900 the remainder is below 100).
  function automatic ucode_t ucode_rom(input logic [UaddrW-1:0] addr);
    ucode_t w;
    w = '0;
    case (addr)
      UA_1000: w = '{10'd1000, CH_M, CH_NONE, UA_1000, UA_900};
      UA_900:  w = '{10'd900,  CH_C, CH_M,    UA_90,   UA_500};
      UA_500:  w = '{10'd500,  CH_D, CH_NONE, UA_100,  UA_400};
      UA_400:  w = '{10'd400,  CH_C, CH_D,    UA_90,   UA_100};
      UA_100:  w = '{10'd100,  CH_C, CH_NONE, UA_100,  UA_90};
      UA_90:   w = '{10'd90,   CH_X, CH_C,    UA_9,    UA_50};
      UA_50:   w = '{10'd50,   CH_L, CH_NONE, UA_10,   UA_40};
      UA_40:   w = '{10'd40,   CH_X, CH_L,    UA_9,    UA_10};
      UA_10:   w = '{10'd10,   CH_X, CH_NONE, UA_10,   UA_9};
      UA_9:    w = '{10'd9,    CH_I, CH_X,    UA_1,    UA_5};
      UA_5:    w = '{10'd5,    CH_V, CH_NONE, UA_1,    UA_4};
      UA_4:    w = '{10'd4,    CH_I, CH_V,    UA_1,    UA_1};
      UA_1:    w = '{10'd1,    CH_I, CH_NONE, UA_1,    UA_1};
      default: w = '{10'd1,    CH_I, CH_NONE, UA_1,    UA_1};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/i2r_if.sv =====
// ----------------------------------------------------------------------------
// i2r_if: valid/ready channels of the integer to Roman encoder
// One interface for the value channel and one for the character channel.
// ----------------------------------------------------------------------------
interface i2r_in_if import i2r_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2r_out_if import i2r_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] roman_char;
  logic             last;
  logic             range_error;

  modport source (output valid, output roman_char, output last, output range_error,
                  input ready);
  modport sink   (input valid, input roman_char, input last, input range_error,
                  output ready);
endinterface

// ===== rtl/core/integer_to_roman_encoder_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_roman_encoder_top: binary value to Roman numeral characters
// Input channel in_i carries a 12-bit value; output channel out_o carries one
// ASCII numeral letter per transfer, with last on the final letter of a run.
// A value of 0 or above 3999 gives a single transfer with range_error set,
// roman_char 0 and last 1.
// A run loads the value, then takes microcode steps: each step sends one letter
// or passes over a microcode step without a letter (a value of 1 passes over
// twelve steps before its first letter). Jumps in the microcode skip steps
// that cannot fit; 3333 sends 12 letters and passes over 12 steps.
// An out-of-range value gives its result without a run. Values are taken one
// at a time: in_i.ready is low while a run is in progress.
// Results leave through a one-entry output register. When the receiver
// stalls, the register holds its transfer and the sequencer waits; nothing is
// dropped. Reset empties the output register and returns the sequencer to
// idle; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder_top import i2r_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  i2r_in_if.sink           in_i,
  i2r_out_if.source        out_o
);

  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] out_char_q, out_char_d;
  logic             out_last_q, out_last_d;
  logic             out_err_q, out_err_d;

  logic             adv;
  logic             in_xfer;
  logic             bad_value;
  logic             busy;
  logic             emit;
  logic [CharW-1:0] emit_char;
  logic             emit_last;
  dp_ctrl_t         dp_ctrl;
  dp_stat_t         dp_stat;

  // Handshake
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = !busy && adv;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign bad_value  = (in_i.value == '0) || (in_i.value > ValueMax);

  i2r_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer && !bad_value),
    .adv_i       (adv),
    .stat_i      (dp_stat),
    .ctrl_o      (dp_ctrl),
    .busy_o      (busy),
    .emit_o      (emit),
    .emit_char_o (emit_char),
    .emit_last_o (emit_last)
  );

  i2r_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (in_i.value),
    .ctrl_i  (dp_ctrl),
    .stat_o  (dp_stat)
  );

  // Output register: error result or sequencer letter
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    if (adv) begin
      out_valid_d = 1'b0;
      if (in_xfer && bad_value) begin
        out_valid_d = 1'b1;
        out_char_d  = CH_NONE;
        out_last_d  = 1'b1;
        out_err_d   = 1'b1;
      end else if (emit) begin
        out_valid_d = 1'b1;
        out_char_d  = emit_char;
        out_last_d  = emit_last;
        out_err_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.roman_char  = out_char_q;
  assign out_o.last        = out_last_q;
  assign out_o.range_error = out_err_q;

`ifndef SYNTH
  // An error transfer is a single, letterless result
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.range_error |-> out_o.last && (out_o.roman_char == CH_NONE))
    else $error("range error transfer without last or with a letter");

  // A good value starts a run in the sequencer
  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !bad_value |=> busy)
    else $error("valid value did not start a run");

  // A run ends only after its last letter was loaded
  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(emit && emit_last && adv))
    else $error("run ended without a last letter");

  // While running, the sequencer never drives an error result
  a_run_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy && emit |-> (emit_char != CH_NONE))
    else $error("sequencer emitted an empty letter");
`endif

endmodule

// ===== rtl/core/i2r_dp.sv =====
// ----------------------------------------------------------------------------
// i2r_dp: remainder datapath
// Holds the part of the value not yet sent, compares it with the amount of
// the current control word and subtracts that amount on command.
// ----------------------------------------------------------------------------
module i2r_dp import i2r_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ValueW-1:0] value_i,
  input  dp_ctrl_t          ctrl_i,
  output dp_stat_t          stat_o
);

  logic [ValueW-1:0] remaining_q, remaining_d;
  logic [ValueW-1:0] amount_ext;
  logic [ValueW-1:0] diff;

  // Compare and subtract
  assign amount_ext = {{(ValueW-AmountW){1'b0}}, ctrl_i.amount};
  assign diff       = remaining_q - amount_ext;

  assign stat_o.ge        = (remaining_q >= amount_ext);
  assign stat_o.diff_zero = (remaining_q == amount_ext);
  assign stat_o.rem_zero  = (remaining_q == '0);

  // Next remainder
  always_comb begin
    remaining_d = remaining_q;
    if (ctrl_i.load) begin
      remaining_d = value_i;
    end else if (ctrl_i.sub) begin
      remaining_d = diff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
    end else begin
      remaining_q <= remaining_d;
    end
  end

endmodule

// ===== rtl/core/i2r_seq.sv =====
// ----------------------------------------------------------------------------
// i2r_seq: microcode sequencer
// Step counter over the microcode table. Each step either sends the first
// letter and subtracts (jump to take target) or moves on (skip target). A
// second letter of a subtractive pair is held and sent in the next step.
// ----------------------------------------------------------------------------
module i2r_seq import i2r_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,     // valid value accepted
  input  logic             adv_i,       // output slot can take a character
  input  dp_stat_t         stat_i,
  output dp_ctrl_t         ctrl_o,
  output logic             busy_o,
  output logic             emit_o,
  output logic [CharW-1:0] emit_char_o,
  output logic             emit_last_o
);

  seq_state_e        state_q, state_d;
  logic [UaddrW-1:0] upc_q, upc_d;
  logic [CharW-1:0]  pending_q, pending_d;
  ucode_t            uw;
  logic              step;
  logic              has_pending;
  logic              done;

  // Control word fetch
  assign uw          = ucode_rom(upc_q);
  assign step        = (state_q == ST_RUN) && adv_i;
  assign has_pending = (pending_q != CH_NONE);

  // Character of this step and whether it ends the run
  always_comb begin
    emit_o      = 1'b0;
    emit_char_o = CH_NONE;
    emit_last_o = 1'b0;
    if (step) begin
      if (has_pending) begin
        emit_o      = 1'b1;
        emit_char_o = pending_q;
        emit_last_o = stat_i.rem_zero;
      end else if (stat_i.ge) begin
        emit_o      = 1'b1;
        emit_char_o = uw.first;
        emit_last_o = stat_i.diff_zero && (uw.second == CH_NONE);
      end
    end
  end

  assign done = emit_o && emit_last_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_RUN;
      ST_RUN:  if (done)    state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Step counter, pending letter and datapath commands
  always_comb begin
    upc_d         = upc_q;
    pending_d     = pending_q;
    ctrl_o.load   = 1'b0;
    ctrl_o.sub    = 1'b0;
    ctrl_o.amount = uw.amount;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          upc_d       = UA_1000;
          pending_d   = CH_NONE;
        end
      end
      ST_RUN: begin
        if (step) begin
          if (has_pending) begin
            pending_d = CH_NONE;
          end else if (stat_i.ge) begin
            ctrl_o.sub = 1'b1;
            pending_d  = uw.second;
            upc_d      = uw.take_addr;
          end else begin
            upc_d = uw.skip_addr;
          end
        end
      end
      default: begin
        upc_d     = UA_1000;
        pending_d = CH_NONE;
      end
    endcase
  end

  assign busy_o = (state_q == ST_RUN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      upc_q     <= UA_1000;
      pending_q <= CH_NONE;
    end else begin
      state_q   <= state_d;
      upc_q     <= upc_d;
      pending_q <= pending_d;
    end
  end

endmodule
